[rtl/bor_pkg.sv]
// ----------------------------------------------------------------------------
// bor_pkg
// Shared constants, overlap modes and pipeline control type for the box
// overlap ratio block.
// ----------------------------------------------------------------------------
package bor_pkg;

    // Default field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int MODE_BITS     = 2;

    // Register indexes (word address)
    localparam logic REG_MODE = 1'b0;

    // Denominator selection; the unused code falls back to union
    typedef enum logic [MODE_BITS-1:0] {
        MODE_UNION = 2'd0,
        MODE_IOMU  = 2'd1,
        MODE_IOFU  = 2'd2
    } overlap_mode_t;

    // Control that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        logic degenerate;
    } bor_ctl_t;

endpackage

[rtl/bor_channels.sv]
// ----------------------------------------------------------------------------
// bor_channels
// Valid/ready channels: a pair of boxes in, one overlap ratio out.
// ----------------------------------------------------------------------------
interface bor_box_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_left;
    logic signed [COORD_BITS-1:0] first_top;
    logic signed [COORD_BITS-1:0] first_width;
    logic signed [COORD_BITS-1:0] first_height;
    logic signed [COORD_BITS-1:0] second_left;
    logic signed [COORD_BITS-1:0] second_top;
    logic signed [COORD_BITS-1:0] second_width;
    logic signed [COORD_BITS-1:0] second_height;

    modport source (
        output valid, first_left, first_top, first_width, first_height,
               second_left, second_top, second_width, second_height,
        input  ready
    );
    modport sink (
        input  valid, first_left, first_top, first_width, first_height,
               second_left, second_top, second_width, second_height,
        output ready
    );
endinterface

interface bor_ratio_if #(
    parameter int FRAC_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   overlap_ratio;
    logic                 degenerate_box;

    modport source (
        output valid, overlap_ratio, degenerate_box,
        input  ready
    );
    modport sink (
        input  valid, overlap_ratio, degenerate_box,
        output ready
    );
endinterface

[rtl/bor_cfg.sv]
// ----------------------------------------------------------------------------
// bor_cfg
// APB register file holding the overlap mode.
// ----------------------------------------------------------------------------
module bor_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bor_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bor_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bor_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output logic [bor_pkg::MODE_BITS-1:0]     mode
);
    import bor_pkg::*;

    logic [MODE_BITS-1:0] mode_reg;
    logic [MODE_BITS-1:0] mode_next;
    logic                 reg_index;
    logic                 wr_en;

    // Word address selects the register; byte lanes are ignored
    assign reg_index = paddr[APB_ADDR_BITS-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    // Update mode on a completed write transfer
    always_comb
    begin
        mode_next = mode_reg;
        if (wr_en && reg_index == REG_MODE)
        begin
            mode_next = pwdata[MODE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UNION;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_MODE)
        begin
            prdata = {{(APB_DATA_BITS-MODE_BITS){1'b0}}, mode_reg};
        end
    end

    assign mode = mode_reg;

endmodule

[rtl/bor_geom.sv]
// ----------------------------------------------------------------------------
// bor_geom
// Three-stage front end: box edges, areas and overlap, then the numerator
// and denominator of the ratio.
// ----------------------------------------------------------------------------
module bor_geom #(
    parameter int COORD_BITS = bor_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         in_valid,
    input  logic [bor_pkg::MODE_BITS-1:0] mode,
    input  logic signed [COORD_BITS-1:0] first_left,
    input  logic signed [COORD_BITS-1:0] first_top,
    input  logic signed [COORD_BITS-1:0] first_width,
    input  logic signed [COORD_BITS-1:0] first_height,
    input  logic signed [COORD_BITS-1:0] second_left,
    input  logic signed [COORD_BITS-1:0] second_top,
    input  logic signed [COORD_BITS-1:0] second_width,
    input  logic signed [COORD_BITS-1:0] second_height,
    output bor_pkg::bor_ctl_t            ctl_out,
    output logic [2*COORD_BITS-2:0]      num_out,
    output logic [2*COORD_BITS-2:0]      den_out
);
    import bor_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int SW = CW - 1;        // positive size
    localparam int AW = 2 * CW - 2;    // area
    localparam int DW = 2 * CW - 1;    // union area

    // ---------------- stage 1: edges ----------------
    logic signed [CW:0]   r1_ext, r2_ext, b1_ext, b2_ext;
    logic                 deg_now;
    bor_ctl_t             ctl1_reg, ctl1_next;
    logic signed [CW-1:0] lx_reg, ty_reg;
    logic signed [CW:0]   rx_reg, by_reg;
    logic [SW-1:0]        w1_reg, h1_reg, w2_reg, h2_reg;

    assign r1_ext = {first_left[CW-1], first_left} + {first_width[CW-1], first_width};
    assign r2_ext = {second_left[CW-1], second_left}
                    + {second_width[CW-1], second_width};
    assign b1_ext = {first_top[CW-1], first_top} + {first_height[CW-1], first_height};
    assign b2_ext = {second_top[CW-1], second_top}
                    + {second_height[CW-1], second_height};

    // Flag any size that is zero or negative
    assign deg_now = first_width[CW-1]   || (first_width == '0)
                  || first_height[CW-1]  || (first_height == '0)
                  || second_width[CW-1]  || (second_width == '0)
                  || second_height[CW-1] || (second_height == '0);

    always_comb
    begin
        ctl1_next.valid      = in_valid;
        ctl1_next.degenerate = deg_now;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lx_reg <= (first_left > second_left) ? first_left : second_left;
            ty_reg <= (first_top > second_top) ? first_top : second_top;
            rx_reg <= (r1_ext < r2_ext) ? r1_ext : r2_ext;
            by_reg <= (b1_ext < b2_ext) ? b1_ext : b2_ext;
            w1_reg <= first_width[SW-1:0];
            h1_reg <= first_height[SW-1:0];
            w2_reg <= second_width[SW-1:0];
            h2_reg <= second_height[SW-1:0];
        end
    end

    // ---------------- stage 2: areas ----------------
    logic signed [CW+1:0] dx, dy;
    logic [SW-1:0]        ow, oh;
    bor_ctl_t             ctl2_reg;
    logic [AW-1:0]        over_reg, area1_reg, area2_reg;

    assign dx = {rx_reg[CW], rx_reg} - {{2{lx_reg[CW-1]}}, lx_reg};
    assign dy = {by_reg[CW], by_reg} - {{2{ty_reg[CW-1]}}, ty_reg};

    // Clamp to zero for disjoint or touching boxes
    assign ow = (!dx[CW+1] && dx != '0) ? dx[SW-1:0] : '0;
    assign oh = (!dy[CW+1] && dy != '0) ? dy[SW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            over_reg  <= AW'(ow) * AW'(oh);
            area1_reg <= AW'(w1_reg) * AW'(h1_reg);
            area2_reg <= AW'(w2_reg) * AW'(h2_reg);
        end
    end

    // ---------------- stage 3: denominator ----------------
    logic [DW-1:0] den_next;
    logic [DW-1:0] den_reg, num_reg;
    bor_ctl_t      ctl3_reg;

    always_comb
    begin
        case (mode)
            MODE_IOMU:
            begin
                den_next = {1'b0, (area1_reg < area2_reg) ? area1_reg : area2_reg};
            end
            MODE_IOFU:
            begin
                den_next = {1'b0, area1_reg};
            end
            default:
            begin
                den_next = {1'b0, area1_reg} + {1'b0, area2_reg} - {1'b0, over_reg};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg <= {1'b0, over_reg};
            den_reg <= den_next;
        end
    end

    // Advance control through the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (advance)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    assign ctl_out = ctl3_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule

[rtl/bor_divider.sv]
// ----------------------------------------------------------------------------
// bor_divider
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS+1
// stages, giving floor(num * 2^FRAC_BITS / den) for num <= den.
// ----------------------------------------------------------------------------
module bor_divider #(
    parameter int DEN_BITS  = 2 * bor_pkg::COORD_BITS_DEF - 1,
    parameter int FRAC_BITS = bor_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  bor_pkg::bor_ctl_t    ctl_in,
    input  logic [DEN_BITS-1:0]  num_in,
    input  logic [DEN_BITS-1:0]  den_in,
    output bor_pkg::bor_ctl_t    ctl_out,
    output logic [FRAC_BITS:0]   ratio_out
);
    import bor_pkg::*;

    localparam int NS = FRAC_BITS + 1;   // stages
    localparam int QW = FRAC_BITS + 1;   // quotient width
    localparam int LS = NS - 1;          // last stage

    logic [DEN_BITS-1:0] rem_src  [0:LS];
    logic [DEN_BITS-1:0] den_src  [0:LS];
    logic [QW-1:0]       q_src    [0:LS];
    bor_ctl_t            ctl_src  [0:LS];
    logic [DEN_BITS-1:0] rem_next [0:LS];
    logic [QW-1:0]       q_next   [0:LS];
    logic [DEN_BITS-1:0] rem_reg  [0:LS];
    logic [DEN_BITS-1:0] den_reg  [0:LS];
    logic [QW-1:0]       q_reg    [0:LS];
    bor_ctl_t            ctl_reg  [0:LS];

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_step
            logic [DEN_BITS:0] cand;
            logic [DEN_BITS:0] diff;
            logic              ge;

            // Stage inputs: the first stage takes the front end
            if (k == 0)
            begin : g_first
                assign rem_src[k] = num_in;
                assign den_src[k] = den_in;
                assign q_src[k]   = '0;
                assign ctl_src[k] = ctl_in;
                assign cand       = {1'b0, rem_src[k]};
            end
            else
            begin : g_next
                assign rem_src[k] = rem_reg[k-1];
                assign den_src[k] = den_reg[k-1];
                assign q_src[k]   = q_reg[k-1];
                assign ctl_src[k] = ctl_reg[k-1];
                assign cand       = {rem_src[k], 1'b0};
            end

            // Trial subtract, keep the remainder when it fits
            assign diff        = cand - {1'b0, den_src[k]};
            assign ge          = (cand >= {1'b0, den_src[k]});
            assign rem_next[k] = ge ? diff[DEN_BITS-1:0] : cand[DEN_BITS-1:0];
            assign q_next[k]   = {q_src[k][QW-2:0], ge};
        end
    endgenerate

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_src[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    // Control shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < NS; i++)
            begin
                ctl_reg[i] <= ctl_src[i];
            end
        end
    end

    // Force zero for degenerate boxes
    assign ctl_out   = ctl_reg[LS];
    assign ratio_out = ctl_reg[LS].degenerate ? '0 : q_reg[LS];

    // Quotient of a valid pair never exceeds one
    a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg[LS].valid && !ctl_reg[LS].degenerate)
        |-> (q_reg[LS] <= (QW'(1) << FRAC_BITS)))
        else $error("ratio exceeds one");

    // Remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg[LS].valid && !ctl_reg[LS].degenerate)
        |-> (rem_reg[LS] < den_reg[LS]))
        else $error("remainder not below divisor");

    // Held result stays put while the pipeline is frozen
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && ctl_reg[LS].valid)
        |=> ($stable(ratio_out) && $stable(ctl_reg[LS])))
        else $error("result changed during stall");

endmodule

[rtl/box_overlap_ratio.sv]
// ----------------------------------------------------------------------------
// box_overlap_ratio
// Overlap ratio of two axis-aligned boxes in fixed point, selectable
// denominator (union, smaller box, first box).
//
//   channel   dir  handshake       payload
//   boxes     in   valid / ready   first_*, second_* (left, top, width, height)
//   result    out  valid / ready   overlap_ratio, degenerate_box
//   apb       in   psel / penable  overlap_mode at word 0
//
// The pipeline has three front-end stages for edges, areas and denominator,
// then one divider stage per quotient bit. One pair is taken every cycle
// unless result stalls; FRAC_BITS sets the divider depth.
// Reset clears all valid bits and sets the mode to union.
// A stall on result freezes the whole pipeline; boxes.ready drops with it.
// ----------------------------------------------------------------------------
module box_overlap_ratio #(
    parameter int COORD_BITS = bor_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bor_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bor_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bor_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bor_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    bor_box_if.sink                           boxes,
    bor_ratio_if.source                       result
);
    import bor_pkg::*;

    localparam int DW = 2 * COORD_BITS - 1;

    logic                 advance;
    logic [MODE_BITS-1:0] mode;
    bor_ctl_t             geom_ctl;
    bor_ctl_t             div_ctl;
    logic [DW-1:0]        num;
    logic [DW-1:0]        den;
    logic [FRAC_BITS:0]   ratio;

    // Move the pipeline when the output slot is free or being taken
    assign advance     = !div_ctl.valid || result.ready;
    assign boxes.ready = advance;

    bor_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    bor_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (boxes.valid),
        .mode          (mode),
        .first_left    (boxes.first_left),
        .first_top     (boxes.first_top),
        .first_width   (boxes.first_width),
        .first_height  (boxes.first_height),
        .second_left   (boxes.second_left),
        .second_top    (boxes.second_top),
        .second_width  (boxes.second_width),
        .second_height (boxes.second_height),
        .ctl_out       (geom_ctl),
        .num_out       (num),
        .den_out       (den)
    );

    bor_divider #(
        .DEN_BITS  (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl_in    (geom_ctl),
        .num_in    (num),
        .den_in    (den),
        .ctl_out   (div_ctl),
        .ratio_out (ratio)
    );

    // Drive the result channel from the last divider stage
    assign result.valid          = div_ctl.valid;
    assign result.overlap_ratio  = ratio;
    assign result.degenerate_box = div_ctl.degenerate;

endmodule
